FILE: sv/arp_proxy_responder_core_defines.svh
// assertion macros for the proxy arp responder
`ifndef ARP_PROXY_RESPONDER_CORE_DEFINES_SVH
`define ARP_PROXY_RESPONDER_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define ARP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define ARP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/arp_prx_pkg.sv
// types and constants for the proxy arp responder
package arp_prx_pkg;

    localparam int unsigned BYTE_W        = 8;
    localparam int unsigned POS_W         = 6;
    localparam int unsigned MAC_W         = 48;
    localparam int unsigned IP_W          = 32;
    localparam int unsigned CFG_INDEX_W   = 8;
    localparam int unsigned CFG_DATA_W    = 48;

    localparam int unsigned ETH_HDR_LEN   = 14;
    localparam int unsigned ARP_HDR_LEN   = 28;
    localparam int unsigned MIN_FRAME_LEN = ETH_HDR_LEN + ARP_HDR_LEN;
    localparam int unsigned REPLY_LEN     = 42;
    localparam int unsigned REPLY_BITS    = REPLY_LEN * BYTE_W;
    localparam int unsigned REPLY_OFF_W   = POS_W + 3;

    localparam logic [POS_W-1:0] INDEX_MAX      = 6'd63;
    localparam logic [POS_W-1:0] MIN_LAST_POS   = 6'(MIN_FRAME_LEN - 1);
    localparam logic [POS_W-1:0] REPLY_LAST_IDX = 6'(REPLY_LEN - 1);

    // field offsets in the received frame
    localparam logic [POS_W-1:0] POS_ETYPE_LO = 6'd12;
    localparam logic [POS_W-1:0] POS_ETYPE_HI = 6'd13;
    localparam logic [POS_W-1:0] POS_HTYPE_LO = 6'd14;
    localparam logic [POS_W-1:0] POS_HTYPE_HI = 6'd15;
    localparam logic [POS_W-1:0] POS_PTYPE_LO = 6'd16;
    localparam logic [POS_W-1:0] POS_PTYPE_HI = 6'd17;
    localparam logic [POS_W-1:0] POS_LENS_LO  = 6'd18;
    localparam logic [POS_W-1:0] POS_LENS_HI  = 6'd19;
    localparam logic [POS_W-1:0] POS_OPER_LO  = 6'd20;
    localparam logic [POS_W-1:0] POS_OPER_HI  = 6'd21;
    localparam logic [POS_W-1:0] POS_SHA_LO   = 6'd22;
    localparam logic [POS_W-1:0] POS_SHA_HI   = 6'd27;
    localparam logic [POS_W-1:0] POS_SPA_LO   = 6'd28;
    localparam logic [POS_W-1:0] POS_SPA_HI   = 6'd31;
    localparam logic [POS_W-1:0] POS_TPA_LO   = 6'd38;
    localparam logic [POS_W-1:0] POS_TPA_HI   = 6'd41;

    localparam logic [15:0] ETYPE_ARP     = 16'h0806;
    localparam logic [15:0] ETYPE_IPV4    = 16'h0800;
    localparam logic [15:0] HTYPE_ETH     = 16'h0001;
    localparam logic [7:0]  HLEN_ETH      = 8'd6;
    localparam logic [7:0]  PLEN_IPV4     = 8'd4;
    localparam logic [15:0] ADDR_LENS_ARP = {HLEN_ETH, PLEN_IPV4};
    localparam logic [15:0] OP_REQUEST    = 16'h0001;
    localparam logic [15:0] OP_REPLY      = 16'h0002;

    localparam logic [MAC_W-1:0] HOST_MAC_RESET    = 48'h52550a000202;
    localparam logic [IP_W-1:0]  SUBNET_ADDR_RESET = 32'h0A000200;
    localparam logic [IP_W-1:0]  SUBNET_MASK_RESET = 32'hFFFFFF00;
    localparam logic [IP_W-1:0]  GUEST_IP_RESET    = 32'h0A00020F;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_HOST_MAC    = 8'd0,
        CFG_SUBNET_ADDR = 8'd1,
        CFG_SUBNET_MASK = 8'd2,
        CFG_GUEST_IP    = 8'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              frame_end;
    } arp_in_t;

    typedef struct packed {
        logic [BYTE_W-1:0] reply_byte;
        logic              reply_last;
    } arp_out_t;

endpackage

FILE: sv/arp_proxy_responder_core.sv
// proxy arp responder: frame parser, request check and reply generator
//
// in channel: one frame byte per transaction (in_valid/in_ready), frame_end on the
// final byte. the parser takes a byte every cycle; only a final byte is held off
// while a reply is still being loaded into the output register.
// out channel: a 42-byte arp reply per answered request (out_valid/out_ready),
// reply_last on the final byte. the request sets the reply counter, which then
// loads the first reply byte into the output register, then one byte per cycle
// while out_ready is high. throughput: one frame byte per cycle, except a final
// byte that waits for the previous reply to finish loading; the reply counter
// emits one byte per cycle while out_ready is high, via a single output register.
// cfg channel: cfg_ready is always high, cfg_index selects host_mac, subnet_addr,
// subnet_mask or guest_ip; other indexes are dropped. write only while idle.
// reset: registers return to their defaults, the byte position to zero, no reply
// pending. a stalled receiver holds the current reply byte and the reply counter;
// frame bytes still flow until the next final byte.
module arp_proxy_responder_core
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  arp_prx_pkg::arp_in_t                 in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output arp_prx_pkg::arp_out_t                out_data,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [arp_prx_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [arp_prx_pkg::CFG_DATA_W-1:0]   cfg_data
);

    import arp_prx_pkg::*;

    `include "arp_proxy_responder_core_defines.svh"

    logic [MAC_W-1:0] host_mac_reg;
    logic [IP_W-1:0]  subnet_addr_reg;
    logic [IP_W-1:0]  subnet_mask_reg;
    logic [IP_W-1:0]  guest_ip_reg;

    logic [POS_W-1:0] byte_index_reg, byte_index_next;
    logic [15:0]      frame_type_reg, frame_type_next;
    logic [15:0]      hw_type_reg, hw_type_next;
    logic [15:0]      proto_type_reg, proto_type_next;
    logic [15:0]      addr_lengths_reg, addr_lengths_next;
    logic [15:0]      operation_reg, operation_next;
    logic [MAC_W-1:0] sender_hw_reg, sender_hw_next;
    logic [IP_W-1:0]  sender_proto_reg, sender_proto_next;
    logic [IP_W-1:0]  target_proto_reg, target_proto_next;

    logic             emit_active_reg;
    logic [POS_W-1:0] emit_idx_reg;
    logic [MAC_W-1:0] rep_sha_reg;
    logic [IP_W-1:0]  rep_spa_reg;
    logic [IP_W-1:0]  rep_tpa_reg;

    logic             out_valid_reg;
    arp_out_t         out_data_reg;

    logic                   in_fire;
    logic                   frame_ok;
    logic                   trigger;
    logic                   emit_load;
    logic [REPLY_BITS-1:0]  reply_frame;
    logic [POS_W-1:0]       reply_pos;
    logic [REPLY_OFF_W-1:0] reply_off;
    logic [BYTE_W-1:0]      b;
    logic [POS_W-1:0]       pos;

    assign in_ready  = !emit_active_reg || !in_data.frame_end;
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign b         = in_data.data_byte;
    assign pos       = byte_index_reg;

    // field capture
    always_comb
    begin
        frame_type_next   = frame_type_reg;
        hw_type_next      = hw_type_reg;
        proto_type_next   = proto_type_reg;
        addr_lengths_next = addr_lengths_reg;
        operation_next    = operation_reg;
        sender_hw_next    = sender_hw_reg;
        sender_proto_next = sender_proto_reg;
        target_proto_next = target_proto_reg;
        if (pos >= POS_ETYPE_LO && pos <= POS_ETYPE_HI)
        begin
            frame_type_next = {frame_type_reg[7:0], b};
        end
        if (pos >= POS_HTYPE_LO && pos <= POS_HTYPE_HI)
        begin
            hw_type_next = {hw_type_reg[7:0], b};
        end
        if (pos >= POS_PTYPE_LO && pos <= POS_PTYPE_HI)
        begin
            proto_type_next = {proto_type_reg[7:0], b};
        end
        if (pos >= POS_LENS_LO && pos <= POS_LENS_HI)
        begin
            addr_lengths_next = {addr_lengths_reg[7:0], b};
        end
        if (pos >= POS_OPER_LO && pos <= POS_OPER_HI)
        begin
            operation_next = {operation_reg[7:0], b};
        end
        if (pos >= POS_SHA_LO && pos <= POS_SHA_HI)
        begin
            sender_hw_next = {sender_hw_reg[MAC_W-BYTE_W-1:0], b};
        end
        if (pos >= POS_SPA_LO && pos <= POS_SPA_HI)
        begin
            sender_proto_next = {sender_proto_reg[IP_W-BYTE_W-1:0], b};
        end
        if (pos >= POS_TPA_LO && pos <= POS_TPA_HI)
        begin
            target_proto_next = {target_proto_reg[IP_W-BYTE_W-1:0], b};
        end

        if (in_data.frame_end)
        begin
            byte_index_next = '0;
        end
        else if (pos < INDEX_MAX)
        begin
            byte_index_next = pos + 6'd1;
        end
        else
        begin
            byte_index_next = pos;
        end
    end

    // request check on the final byte
    assign frame_ok = (pos >= MIN_LAST_POS)
                   && (frame_type_next == ETYPE_ARP)
                   && (hw_type_next == HTYPE_ETH)
                   && (proto_type_next == ETYPE_IPV4)
                   && (addr_lengths_next == ADDR_LENS_ARP)
                   && (operation_next == OP_REQUEST)
                   && ((target_proto_next & subnet_mask_reg) == subnet_addr_reg)
                   && (target_proto_next != guest_ip_reg);

    assign trigger = in_fire && in_data.frame_end && frame_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg   <= '0;
            frame_type_reg   <= '0;
            hw_type_reg      <= '0;
            proto_type_reg   <= '0;
            addr_lengths_reg <= '0;
            operation_reg    <= '0;
            sender_hw_reg    <= '0;
            sender_proto_reg <= '0;
            target_proto_reg <= '0;
        end
        else if (in_fire)
        begin
            byte_index_reg   <= byte_index_next;
            frame_type_reg   <= frame_type_next;
            hw_type_reg      <= hw_type_next;
            proto_type_reg   <= proto_type_next;
            addr_lengths_reg <= addr_lengths_next;
            operation_reg    <= operation_next;
            sender_hw_reg    <= sender_hw_next;
            sender_proto_reg <= sender_proto_next;
            target_proto_reg <= target_proto_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            host_mac_reg    <= HOST_MAC_RESET;
            subnet_addr_reg <= SUBNET_ADDR_RESET;
            subnet_mask_reg <= SUBNET_MASK_RESET;
            guest_ip_reg    <= GUEST_IP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_HOST_MAC:    host_mac_reg    <= cfg_data;
                CFG_SUBNET_ADDR: subnet_addr_reg <= cfg_data[IP_W-1:0];
                CFG_SUBNET_MASK: subnet_mask_reg <= cfg_data[IP_W-1:0];
                CFG_GUEST_IP:    guest_ip_reg    <= cfg_data[IP_W-1:0];
                default:         ;
            endcase
        end
    end

    // reply snapshot
    always_ff @(posedge clk)
    begin
        if (trigger)
        begin
            rep_sha_reg <= sender_hw_next;
            rep_spa_reg <= sender_proto_next;
            rep_tpa_reg <= target_proto_next;
        end
    end

    assign reply_frame = {rep_sha_reg, host_mac_reg, ETYPE_ARP, HTYPE_ETH, ETYPE_IPV4,
                          HLEN_ETH, PLEN_IPV4, OP_REPLY, host_mac_reg, rep_tpa_reg,
                          rep_sha_reg, rep_spa_reg};
    assign reply_pos   = REPLY_LAST_IDX - emit_idx_reg;
    assign reply_off   = {reply_pos, 3'b000};
    assign emit_load   = emit_active_reg && (!out_valid_reg || out_ready);

    // reply byte counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emit_active_reg <= 1'b0;
            emit_idx_reg    <= '0;
        end
        else if (trigger)
        begin
            emit_active_reg <= 1'b1;
            emit_idx_reg    <= '0;
        end
        else if (emit_load)
        begin
            if (emit_idx_reg == REPLY_LAST_IDX)
            begin
                emit_active_reg <= 1'b0;
                emit_idx_reg    <= '0;
            end
            else
            begin
                emit_idx_reg <= emit_idx_reg + 6'd1;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_load)
        begin
            out_data_reg.reply_byte <= reply_frame[reply_off +: BYTE_W];
            out_data_reg.reply_last <= (emit_idx_reg == REPLY_LAST_IDX);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `ARP_ASSERT_NOW(a_idle_idx_zero, !emit_active_reg, emit_idx_reg == '0, "idx not cleared")
    `ARP_ASSERT_NOW(a_idx_range, 1'b1, emit_idx_reg <= REPLY_LAST_IDX, "idx out of range")
    `ARP_ASSERT_NOW(a_end_not_busy, in_fire && in_data.frame_end, !emit_active_reg, "end busy")
    `ARP_ASSERT_NEXT(a_trig_starts, trigger, emit_active_reg && emit_idx_reg == '0, "no start")

endmodule

FILE: verif/arp_proxy_responder_core_tb.sv
// self-checking testbench for the proxy arp responder core
module arp_proxy_responder_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import arp_prx_pkg::*;

    localparam int HOLD_CYCLES    = 200;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int TAIL_CYCLES    = 16;
    localparam int MAX_SHOWN      = 10;

    localparam logic [CFG_INDEX_W-1:0] CFG_INDEX_SPARE = 8'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_INDEX_TOP   = 8'hFF;
    localparam logic [15:0]            OP_SWAPPED      = 16'h0100;
    localparam logic [IP_W-1:0]        IP_NEIGHBOR     = 32'h0A00_0201;
    localparam logic [IP_W-1:0]        IP_NET_TOP      = 32'h0A00_02FF;
    localparam logic [MAC_W-1:0]       MAC_ONES        = 48'hFFFF_FFFF_FFFF;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    arp_in_t                in_data;
    logic                   out_valid;
    logic                   out_ready;
    arp_out_t               out_data;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // register copies
    logic [MAC_W-1:0] cur_host_mac;
    logic [IP_W-1:0]  cur_subnet;
    logic [IP_W-1:0]  cur_mask;
    logic [IP_W-1:0]  cur_guest;

    // fields captured from the incoming frame
    logic [POS_W-1:0] rx_pos;
    logic [15:0]      seen_etype;
    logic [15:0]      seen_htype;
    logic [15:0]      seen_ptype;
    logic [15:0]      seen_lens;
    logic [15:0]      seen_oper;
    logic [MAC_W-1:0] seen_sha;
    logic [IP_W-1:0]  seen_spa;
    logic [IP_W-1:0]  seen_tpa;

    arp_out_t    reply_bytes[$];
    logic [7:0]  tx_frame[$];

    int mismatches      = 0;
    int out_pos         = 0;
    int replies_checked = 0;
    int frames_sent     = 0;
    int cfg_writes      = 0;
    int tx_gap_pct      = 0;
    int rx_stall_pct    = 0;
    bit hold_request    = 1'b0;

    arp_proxy_responder_core i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic void absorb_frame_byte(arp_in_t item);
        logic [POS_W-1:0]      pos;
        logic [REPLY_BITS-1:0] reply_bits;
        int                    i;
        pos = rx_pos;
        if (pos >= POS_ETYPE_LO && pos <= POS_ETYPE_HI)
            seen_etype = {seen_etype[7:0], item.data_byte};
        else if (pos >= POS_HTYPE_LO && pos <= POS_HTYPE_HI)
            seen_htype = {seen_htype[7:0], item.data_byte};
        else if (pos >= POS_PTYPE_LO && pos <= POS_PTYPE_HI)
            seen_ptype = {seen_ptype[7:0], item.data_byte};
        else if (pos >= POS_LENS_LO && pos <= POS_LENS_HI)
            seen_lens = {seen_lens[7:0], item.data_byte};
        else if (pos >= POS_OPER_LO && pos <= POS_OPER_HI)
            seen_oper = {seen_oper[7:0], item.data_byte};
        else if (pos >= POS_SHA_LO && pos <= POS_SHA_HI)
            seen_sha = {seen_sha[MAC_W-9:0], item.data_byte};
        else if (pos >= POS_SPA_LO && pos <= POS_SPA_HI)
            seen_spa = {seen_spa[IP_W-9:0], item.data_byte};
        else if (pos >= POS_TPA_LO && pos <= POS_TPA_HI)
            seen_tpa = {seen_tpa[IP_W-9:0], item.data_byte};

        if (!item.frame_end)
        begin
            if (pos != INDEX_MAX)
                rx_pos = pos + 1'b1;
            return;
        end
        rx_pos = '0;
        if (pos < MIN_LAST_POS || seen_etype != ETYPE_ARP || seen_htype != HTYPE_ETH ||
            seen_ptype != ETYPE_IPV4 || seen_lens != ADDR_LENS_ARP ||
            seen_oper != OP_REQUEST || (seen_tpa & cur_mask) != cur_subnet ||
            seen_tpa == cur_guest)
            return;
        reply_bits = {seen_sha, cur_host_mac, ETYPE_ARP, HTYPE_ETH, ETYPE_IPV4, HLEN_ETH,
                      PLEN_IPV4, OP_REPLY, cur_host_mac, seen_tpa, seen_sha, seen_spa};
        for (i = 0; i < REPLY_LEN; i++)
            reply_bytes.push_back('{reply_byte: reply_bits[REPLY_BITS-1-8*i -: 8],
                                    reply_last: (i == REPLY_LEN - 1)});
    endfunction

    function automatic void note_mismatch(string what, logic [7:0] want, logic [7:0] got);
        mismatches++;
        if (mismatches <= MAX_SHOWN)
            $display("%0t: reply byte %0d %s expected %h got %h", $realtime, out_pos, what,
                     want, got);
    endfunction

    always @(posedge clk)
    begin : arp_scoreboard
        arp_out_t want;
        if (!rst_n)
        begin
            cur_host_mac = HOST_MAC_RESET;
            cur_subnet   = SUBNET_ADDR_RESET;
            cur_mask     = SUBNET_MASK_RESET;
            cur_guest    = GUEST_IP_RESET;
            rx_pos       = '0;
            seen_etype   = '0;
            seen_htype   = '0;
            seen_ptype   = '0;
            seen_lens    = '0;
            seen_oper    = '0;
            seen_sha     = '0;
            seen_spa     = '0;
            seen_tpa     = '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                cfg_writes++;
                case (cfg_index)
                    CFG_HOST_MAC:    cur_host_mac = cfg_data[MAC_W-1:0];
                    CFG_SUBNET_ADDR: cur_subnet   = cfg_data[IP_W-1:0];
                    CFG_SUBNET_MASK: cur_mask     = cfg_data[IP_W-1:0];
                    CFG_GUEST_IP:    cur_guest    = cfg_data[IP_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                absorb_frame_byte(in_data);
            if (out_valid && out_ready)
            begin
                if (reply_bytes.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("%0t: unexpected reply byte %h last %b", $realtime,
                                 out_data.reply_byte, out_data.reply_last);
                end
                else
                begin
                    want = reply_bytes.pop_front();
                    if (out_data.reply_byte !== want.reply_byte)
                        note_mismatch("data", want.reply_byte, out_data.reply_byte);
                    if (out_data.reply_last !== want.reply_last)
                        note_mismatch("last", 8'(want.reply_last), 8'(out_data.reply_last));
                end
                out_pos++;
                if (out_data.reply_last === 1'b1)
                begin
                    replies_checked++;
                    out_pos = 0;
                end
            end
        end
    end

    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
                (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("timeout after %0d cycles without a transaction", WATCHDOG_LIMIT);
        $display("arp_proxy_responder_core test failed");
        $finish;
    end

    initial
    begin : reply_sink
        out_ready = 1'b1;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                out_ready    = 1'b1;
                hold_request = 1'b0;
            end
            else if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct)
            begin
                out_ready = 1'b0;
                repeat ($urandom_range(1, 11)) @(negedge clk);
                out_ready = 1'b1;
            end
        end
    end

    task automatic send_byte(input logic [7:0] value, input logic last);
        if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        in_valid = 1'b1;
        in_data  = '{data_byte: value, frame_end: last};
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    task automatic send_frame();
        int i;
        for (i = 0; i < tx_frame.size(); i++)
            send_byte(tx_frame[i], i == tx_frame.size() - 1);
        frames_sent++;
    endtask

    task automatic wait_drained(input int settle);
        in_valid = 1'b0;
        while (reply_bytes.size() != 0) @(negedge clk);
        repeat (settle) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        wait_drained(SETTLE_CYCLES);
        cfg_valid = 1'b1;
        cfg_index = index;
        cfg_data  = value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // arp frame of the given length, padded or cut
    task automatic build_arp(input logic [15:0] oper, input logic [MAC_W-1:0] sha,
                             input logic [IP_W-1:0] spa, input logic [IP_W-1:0] tpa,
                             input int len);
        logic [REPLY_BITS-1:0] hdr;
        logic [MAC_W-1:0]      dst;
        logic [MAC_W-1:0]      tha;
        logic [63:0]           r64;
        int                    i;
        r64 = {$urandom, $urandom};
        dst = $urandom_range(0, 1) ? MAC_ONES : r64[MAC_W-1:0];
        r64 = {$urandom, $urandom};
        tha = r64[MAC_W-1:0];
        hdr = {dst, sha, ETYPE_ARP, HTYPE_ETH, ETYPE_IPV4, HLEN_ETH, PLEN_IPV4, oper, sha,
               spa, tha, tpa};
        tx_frame.delete();
        for (i = 0; i < len; i++)
            tx_frame.push_back(i < REPLY_LEN ? hdr[REPLY_BITS-1-8*i -: 8] : 8'($urandom));
    endtask

    task automatic test_reset_defaults();
        build_arp(OP_REQUEST, 48'h0200_0000_0001, GUEST_IP_RESET, IP_NEIGHBOR,
                  MIN_FRAME_LEN);
        send_frame();
        wait_drained(SETTLE_CYCLES);
    endtask

    task automatic test_header_checks();
        int fault;
        fault = $urandom_range(0, 6);
        build_arp(fault == 5 ? OP_REPLY : (fault == 6 ? OP_SWAPPED : OP_REQUEST),
                  48'h0200_0000_0010, GUEST_IP_RESET, IP_NET_TOP, MIN_FRAME_LEN);
        case (fault)
            0: tx_frame[POS_ETYPE_HI] = ETYPE_IPV4[7:0];
            1: tx_frame[POS_HTYPE_HI] = 8'h02;
            2:
            begin
                tx_frame[POS_PTYPE_LO] = 8'h86;
                tx_frame[POS_PTYPE_HI] = 8'hDD;
            end
            3: tx_frame[POS_LENS_LO] = 8'd8;
            4: tx_frame[POS_LENS_HI] = 8'd16;
            default: ;
        endcase
        send_frame();
        wait_drained(SETTLE_CYCLES);
    endtask

    task automatic test_frame_lengths();
        // one byte short of a full request
        build_arp(OP_REQUEST, 48'h0200_0000_0020, GUEST_IP_RESET, IP_NEIGHBOR,
                  MIN_FRAME_LEN - 1);
        send_frame();
        wait_drained(SETTLE_CYCLES);
    endtask

    task automatic test_register_extremes();
        write_reg(CFG_HOST_MAC, {CFG_DATA_W{1'b1}});
        write_reg(CFG_SUBNET_MASK, {16'hFFFF, 32'hFFFF_FFFF});
        write_reg(CFG_SUBNET_ADDR, {16'hA5A5, 32'hC0A8_0001});
        write_reg(CFG_GUEST_IP, {16'hFFFF, 32'h0000_0000});
        // indexes past the register list change nothing
        write_reg(CFG_INDEX_SPARE, '0);
        write_reg(CFG_INDEX_TOP, {CFG_DATA_W{1'b1}});
    endtask

    task automatic test_backpressure();
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        hold_request = 1'b1;
        // long request past the saturated position, answered under the new registers
        build_arp(OP_REQUEST, MAC_ONES, 32'hC0A8_0002, 32'hC0A8_0001, int'(INDEX_MAX) + 2);
        send_frame();
        // lone final byte waits behind the held reply
        tx_frame.delete();
        tx_frame.push_back(8'hFF);
        send_frame();
        wait_drained(0);
    endtask

    initial
    begin : run
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        tx_gap_pct   = 10;
        rx_stall_pct = 10;
        test_reset_defaults();
        test_header_checks();
        test_frame_lengths();
        test_register_extremes();
        test_backpressure();
        wait_drained(TAIL_CYCLES);

        $display("sent %0d frames (short, long, malformed and proxy requests), %0d replies",
                 frames_sent, replies_checked);
        $display("checked byte by byte over %0d register writes and a %0d-cycle sink stall",
                 cfg_writes, HOLD_CYCLES);
        if (reply_bytes.size() != 0)
            $display("%0d reply bytes never arrived", reply_bytes.size());
        if (mismatches == 0 && reply_bytes.size() == 0)
            $display("arp_proxy_responder_core test passed");
        else
            $display("arp_proxy_responder_core test failed");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+sv
sv/arp_prx_pkg.sv
sv/arp_proxy_responder_core.sv
verif/arp_proxy_responder_core_tb.sv
